/* design/fre_pkg.sv */
// Shared constants and types for the frame RMS envelope block.
// No dependencies; imported by frame_rms_envelope.
`timescale 1ns / 1ps

package fre_pkg;

   // frame length in samples
   localparam int FRAME_LEN = 256;

   // field and datapath widths
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = $clog2(FRAME_LEN + 1);
   localparam int SUM_W    = 2 * (SAMPLE_W - 1) + COUNT_W;
   localparam int MEAN_W   = 2 * SAMPLE_W;
   localparam int ROOT_W   = SAMPLE_W;
   localparam int STEP_W   = $clog2(SUM_W);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ROOT,
      ST_EMIT
   } state_type;

endpackage

/* design/frame_rms_envelope.sv */
// Frame RMS envelope: bit-serial square, divide and square root over one frame.
// Depends on fre_pkg for widths, frame length and the sequencer states.
`timescale 1ns / 1ps

// Each accepted sample is squared one multiplier bit per cycle and added to the
// frame's sum of squares; the next sample is taken only after the squaring is
// done. When the frame reaches FRAME_LEN samples, or a sample marked last
// arrives, the sum is divided by the sample count one quotient bit per cycle
// and the floored mean goes through a digit-by-digit square root, one root
// bit per cycle; the ST_EMIT state then places the result in the output
// register once that register is free. No new sample is accepted before then,
// and the wait is longer if an earlier result has not been taken yet. The
// output register holds one result while new samples are accepted.
module frame_rms_envelope
   import fre_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic        [ROOT_W-1:0]   rsp_rms,
   output logic        [COUNT_W-1:0]  rsp_frame_samples
);

   state_type state_ff, state_in;

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                last_ff, last_in;
   logic [SAMPLE_W-1:0] mplr_ff, mplr_in;
   logic [MEAN_W-1:0]   mcand_ff, mcand_in;
   logic [COUNT_W-1:0]  divisor_ff, divisor_in;
   logic [SUM_W-1:0]    quot_ff, quot_in;
   logic [COUNT_W-1:0]  drem_ff, drem_in;
   logic [MEAN_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W:0]     srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]   rsp_rms_ff, rsp_rms_in;
   logic [COUNT_W-1:0]  rsp_frame_ff, rsp_frame_in;

   logic                req_accept;
   logic                rsp_taken;
   logic                out_free;
   logic                step_last;
   logic                frame_done;
   logic [SAMPLE_W-1:0] sample_bits;
   logic [SAMPLE_W-1:0] mag;
   logic [SUM_W-1:0]    partial;
   logic [SUM_W-1:0]    sum_add;
   logic [COUNT_W:0]    dshift;
   logic [COUNT_W:0]    ddiff;
   logic                dfit;
   logic [ROOT_W+2:0]   sshift;
   logic [ROOT_W+2:0]   strial;
   logic [ROOT_W+2:0]   sdiff;
   logic                sfit;

   // handshake terms
   assign req_accept = req_valid && !req_stall;
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || rsp_taken;
   assign frame_done = (count_ff == COUNT_W'(FRAME_LEN)) || last_ff;

   // last iteration of the current serial operation
   always_comb begin
      case (state_ff)
         ST_SQUARE: step_last = (step_ff == STEP_W'(SAMPLE_W - 1));
         ST_DIVIDE: step_last = (step_ff == STEP_W'(SUM_W - 1));
         ST_ROOT:   step_last = (step_ff == STEP_W'(ROOT_W - 1));
         default:   step_last = 1'b0;
      endcase
   end

   // sample magnitude, 0 to 32768
   assign sample_bits = req_sample;
   assign mag = sample_bits[SAMPLE_W-1] ? ((~sample_bits) + SAMPLE_W'(1)) : sample_bits;

   // shift-add multiply step
   assign partial = mplr_ff[0] ? SUM_W'(mcand_ff) : '0;
   assign sum_add = sum_ff + partial;

   // restoring divide step
   assign dshift = {drem_ff, quot_ff[SUM_W-1]};
   assign dfit   = (dshift >= {1'b0, divisor_ff});
   assign ddiff  = dshift - {1'b0, divisor_ff};

   // square root step, two radicand bits per root bit
   assign sshift = {srem_ff, rad_ff[MEAN_W-1 -: 2]};
   assign strial = {1'b0, root_ff, 2'b01};
   assign sfit   = (sshift >= strial);
   assign sdiff  = sshift - strial;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (step_last) state_in = frame_done ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (step_last) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (step_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = reset || (state_ff != ST_IDLE);
   end

   // datapath next values
   always_comb begin
      step_in      = step_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      mplr_in      = mplr_ff;
      mcand_in     = mcand_ff;
      divisor_in   = divisor_ff;
      quot_in      = quot_ff;
      drem_in      = drem_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_taken;
      rsp_rms_in   = rsp_rms_ff;
      rsp_frame_in = rsp_frame_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_accept) begin
               mplr_in  = mag;
               mcand_in = MEAN_W'(mag);
               last_in  = req_last_sample;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ST_SQUARE: begin
            sum_in   = sum_add;
            mplr_in  = mplr_ff >> 1;
            mcand_in = mcand_ff << 1;
            step_in  = step_ff + STEP_W'(1);
            if (step_last) begin
               step_in = '0;
               if (frame_done) begin
                  quot_in    = sum_add;
                  drem_in    = '0;
                  divisor_in = count_ff;
                  sum_in     = '0;
                  count_in   = '0;
               end
            end
         end
         ST_DIVIDE: begin
            drem_in = dfit ? ddiff[COUNT_W-1:0] : dshift[COUNT_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], dfit};
            step_in = step_ff + STEP_W'(1);
            if (step_last) begin
               step_in = '0;
               rad_in  = {quot_ff[MEAN_W-2:0], dfit};
               srem_in = '0;
               root_in = '0;
            end
         end
         ST_ROOT: begin
            srem_in = sfit ? sdiff[ROOT_W:0] : sshift[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], sfit};
            rad_in  = rad_ff << 2;
            step_in = step_last ? '0 : step_ff + STEP_W'(1);
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = root_ff;
               rsp_frame_in = divisor_ff;
            end
         end
         default: step_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      last_ff      <= last_in;
      mplr_ff      <= mplr_in;
      mcand_ff     <= mcand_in;
      divisor_ff   <= divisor_in;
      quot_ff      <= quot_in;
      drem_ff      <= drem_in;
      rad_ff       <= rad_in;
      srem_ff      <= srem_in;
      root_ff      <= root_in;
      rsp_rms_ff   <= rsp_rms_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rms           = rsp_rms_ff;
   assign rsp_frame_samples = rsp_frame_ff;

endmodule

/* sim/tb.sv */
// Self-checking testbench for frame_rms_envelope: random and directed sample streams.
// Depends on fre_pkg and frame_rms_envelope; checks each frame result against its own
// frame-energy predictor.
`timescale 1ns / 1ps

module tb
   import fre_pkg::*;
();

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 1100;
   localparam int MIN_FRAMES   = 40;
   localparam logic signed [SAMPLE_W-1:0] MOST_NEG = -(2 ** (SAMPLE_W - 1));
   localparam logic signed [SAMPLE_W-1:0] MOST_POS = (2 ** (SAMPLE_W - 1)) - 1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } audio_sample_type;

   typedef struct packed {
      logic [ROOT_W-1:0]  rms;
      logic [COUNT_W-1:0] frame_samples;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic req_last_sample = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ROOT_W-1:0] rsp_rms;
   logic [COUNT_W-1:0] rsp_frame_samples;

   audio_sample_type sample_queue[$];
   frame_result_type frame_expected[$];

   // predictor state for the frame in progress
   longint unsigned energy_sum = 0;
   int unsigned     energy_count = 0;

   // stimulus bookkeeping
   int unsigned gen_count = 0;
   int unsigned gen_frames = 0;
   int unsigned total_items = 0;
   int unsigned items_sent = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sender_idle_pct = 18;
   int unsigned receiver_idle_pct = 59;
   logic sample_taken = 1'b0;

   frame_rms_envelope uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_last_sample   (req_last_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rms           (rsp_rms),
      .rsp_frame_samples (rsp_frame_samples)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // floor of the integer square root, one root bit at a time from the top
   function automatic logic [ROOT_W:0] floor_root(longint unsigned value);
      logic [ROOT_W:0] root;
      logic [ROOT_W:0] trial;
      root = '0;
      for (int b = ROOT_W; b >= 0; b--) begin
         trial = root | ((ROOT_W + 1)'(1) << b);
         if (64'(trial) * 64'(trial) <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // add one sample to the frame energy, close the frame when full or marked last
   task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] sample,
                                    input logic last);
      longint unsigned  magnitude;
      frame_result_type result;
      magnitude = (sample < 0) ? longint'(-int'(sample)) : longint'(int'(sample));
      energy_sum += magnitude * magnitude;
      energy_count++;
      if (energy_count >= FRAME_LEN || last) begin
         result.rms = ROOT_W'(floor_root(energy_sum / energy_count));
         result.frame_samples = COUNT_W'(energy_count);
         frame_expected.push_back(result);
         energy_sum = 0;
         energy_count = 0;
      end
   endtask

   // queue one stimulus sample and keep count of the frames it closes
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] sample, input logic last);
      audio_sample_type item;
      item.sample = sample;
      item.last = last;
      sample_queue.push_back(item);
      gen_count++;
      if (gen_count >= FRAME_LEN || last) begin
         gen_frames++;
         gen_count = 0;
      end
   endtask

   // random sample in one of several amplitude styles
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned style);
      logic signed [SAMPLE_W-1:0] value;
      case (style)
         0: begin
            value = SAMPLE_W'($urandom);
         end
         1: begin
            value = SAMPLE_W'($signed($urandom_range(64)) - 32);
         end
         2: begin
            value = $urandom_range(1) ? MOST_NEG : MOST_POS;
         end
         default: begin
            value = SAMPLE_W'($signed($urandom_range(8192)) - 4096);
         end
      endcase
      return value;
   endfunction

   // driver: present queued transactions, hold until accepted, idle at random
   always @(negedge clock) begin
      logic next_valid;
      audio_sample_type next_item;
      next_valid = req_valid;
      next_item.sample = req_sample;
      next_item.last = req_last_sample;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || sample_taken) begin
         if (sample_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_item = sample_queue.pop_front();
            next_valid = 1'b1;
            items_sent++;
            // idling pattern moves through three phases over the run
            if (items_sent < total_items / 3) begin
               sender_idle_pct <= 18;
               receiver_idle_pct <= 59;
            end else if (items_sent < 2 * total_items / 3) begin
               sender_idle_pct <= 59;
               receiver_idle_pct <= 18;
            end else begin
               sender_idle_pct <= 0;
               receiver_idle_pct <= 0;
            end
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
      req_sample <= next_item.sample;
      req_last_sample <= next_item.last;
      rsp_stall <= !reset && ($urandom_range(99) < receiver_idle_pct);
   end

   // monitor: check result transactions, feed accepted samples to the predictor
   always @(posedge clock) begin
      frame_result_type wanted;
      sample_taken = req_valid && !req_stall && !reset;
      if (reset) begin
         energy_sum = 0;
         energy_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_expected.size() == 0) begin
               $display("%0t: unexpected result, rms %0d, frame_samples %0d",
                        $time, rsp_rms, rsp_frame_samples);
               mismatch_count++;
            end else begin
               wanted = frame_expected.pop_front();
               if (rsp_rms !== wanted.rms) begin
                  $display("%0t: rms mismatch, expected %0d, actual %0d",
                           $time, wanted.rms, rsp_rms);
                  mismatch_count++;
               end
               if (rsp_frame_samples !== wanted.frame_samples) begin
                  $display("%0t: frame_samples mismatch, expected %0d, actual %0d",
                           $time, wanted.frame_samples, rsp_frame_samples);
                  mismatch_count++;
               end
            end
         end
         if (sample_taken) begin
            accumulate_sample(req_sample, req_last_sample);
         end
      end
   end

   // stimulus generation, reset and end of run
   initial begin
      int unsigned kind;
      int unsigned len;
      int unsigned style;
      int unsigned frame_index;
      logic last_on_end;

      // directed: single-sample frames at the field extremes and around zero
      push_sample(MOST_NEG, 1'b1);
      push_sample(MOST_POS, 1'b1);
      push_sample(0, 1'b1);
      push_sample(-1, 1'b1);
      push_sample(1, 1'b1);
      // directed: short partial frames mixing extremes
      push_sample(MOST_POS, 1'b0);
      push_sample(MOST_NEG, 1'b0);
      push_sample(0, 1'b0);
      push_sample(1, 1'b1);
      push_sample(-1, 1'b0);
      push_sample(1, 1'b0);
      push_sample(-32767, 1'b1);
      push_sample(0, 1'b0);
      push_sample(0, 1'b1);
      push_sample(MOST_NEG, 1'b0);
      push_sample(MOST_NEG, 1'b1);

      // random frames: mostly short flushed frames, some full and overlong ones
      frame_index = 0;
      while (sample_queue.size() < RANDOM_ITEMS || gen_frames < MIN_FRAMES) begin
         kind = $urandom_range(99);
         style = $urandom_range(3);
         last_on_end = 1'b1;
         // first a full-scale full frame closed by the last mark, then a plain full one
         if (frame_index == 0) begin
            kind = 0;
         end else if (frame_index == 1) begin
            kind = 5;
            last_on_end = 1'b0;
         end
         if (kind < 3) begin
            // full frame of the most negative value, largest possible energy
            if (frame_index != 0) begin
               last_on_end = $urandom_range(1);
            end
            for (int i = 0; i < FRAME_LEN; i++) begin
               push_sample(MOST_NEG, (i == FRAME_LEN - 1) && last_on_end);
            end
         end else if (kind < 7) begin
            // full frame, last mark on the final sample or not
            if (frame_index > 1) begin
               last_on_end = $urandom_range(1);
            end
            for (int i = 0; i < FRAME_LEN; i++) begin
               push_sample(pick_sample(style), (i == FRAME_LEN - 1) && last_on_end);
            end
         end else if (kind < 9) begin
            // longer than a frame, remainder flushed by the last mark
            len = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 150);
            for (int i = 0; i < len; i++) begin
               push_sample(pick_sample(style), i == len - 1);
            end
         end else if (kind < 12) begin
            // noise: stray last marks anywhere
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               push_sample(pick_sample(style), $urandom_range(3) == 0);
            end
         end else begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
               push_sample(pick_sample(style), i == len - 1);
            end
         end
         frame_index++;
      end
      total_items = sample_queue.size();

      // hold synchronous reset, then release it on a falling clock edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain stimulus, then expectations, then allow for late extra results
      while (sample_queue.size() > 0 || req_valid) begin
         @(posedge clock);
      end
      while (frame_expected.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
